>>> hw/rtl/ifwp_pkg.sv
// shared constants, types and character helpers for the integer formatter
package ifwp_pkg;

  localparam int MAX_WIDTH_DEF = 32;
  localparam int VALUE_W       = 32;
  localparam int NDEC          = 10;
  localparam int NHEX          = VALUE_W / 4;
  localparam int DIG_W         = NDEC * 4;
  localparam int ND_W          = 4;
  localparam int BIT_CNT_W     = $clog2(VALUE_W);

  localparam int RIGHT_FILL_BIT = 0;
  localparam int ZERO_FILL_BIT  = 1;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  typedef struct packed {
    logic            lead_minus;
    logic            text_minus;
    logic            zero_fill;
    logic            right_fill;
    logic            upper;
    logic [ND_W-1:0] ndig;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] base;
    base = up ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'h0, d};
    end else begin
      digit_char = base + {4'h0, d} - 8'd10;
    end
  endfunction

endpackage

>>> hw/rtl/ifwp_conv.sv
// bit-serial binary to digit converter with leading zero strip
module ifwp_conv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ifwp_pkg::VALUE_W-1:0] mag,
  input  logic                        hex,
  output logic                        done,
  output logic [ifwp_pkg::DIG_W-1:0]  digits,
  output logic [ifwp_pkg::ND_W-1:0]   ndig
);

  typedef enum logic [1:0] {C_IDLE, C_DAB, C_STRIP} cstate_t;

  cstate_t                           state_r, state_nxt;
  logic [ifwp_pkg::DIG_W-1:0]        bcd_r, bcd_nxt, adj;
  logic [ifwp_pkg::VALUE_W-1:0]      mag_r, mag_nxt;
  logic [ifwp_pkg::BIT_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ifwp_pkg::ND_W-1:0]         nd_r, nd_nxt;
  logic                              done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < ifwp_pkg::NDEC; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r;
    nd_nxt    = nd_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          if (hex) begin
            bcd_nxt   = {mag, {(ifwp_pkg::DIG_W - ifwp_pkg::VALUE_W){1'b0}}};
            nd_nxt    = ifwp_pkg::ND_W'(ifwp_pkg::NHEX);
            state_nxt = C_STRIP;
          end else begin
            bcd_nxt   = '0;
            mag_nxt   = mag;
            cnt_nxt   = '0;
            nd_nxt    = ifwp_pkg::ND_W'(ifwp_pkg::NDEC);
            state_nxt = C_DAB;
          end
        end
      end
      C_DAB: begin
        bcd_nxt = {adj[ifwp_pkg::DIG_W-2:0], mag_r[ifwp_pkg::VALUE_W-1]};
        mag_nxt = {mag_r[ifwp_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = C_STRIP;
        end
      end
      C_STRIP: begin
        if (nd_r > ifwp_pkg::ND_W'(1) && bcd_r[ifwp_pkg::DIG_W-1 -: 4] == 4'h0) begin
          bcd_nxt = {bcd_r[ifwp_pkg::DIG_W-5:0], 4'h0};
          nd_nxt  = nd_r - 1'b1;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    bcd_r <= bcd_nxt;
    mag_r <= mag_nxt;
    cnt_r <= cnt_nxt;
    nd_r  <= nd_nxt;
  end

  assign done   = done_r;
  assign digits = bcd_r;
  assign ndig   = nd_r;

endmodule

>>> hw/rtl/ifwp_emit.sv
// character sequencer: sign, padding and digits out through one output register
module ifwp_emit #(
  parameter int CW = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ifwp_pkg::job_t             job,
  input  logic [CW-1:0]              pad_cnt,
  input  logic [ifwp_pkg::DIG_W-1:0] digits,
  output logic                       ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_char,
  output logic                       out_last
);

  logic                       busy_r, busy_nxt;
  logic                       lead_r, lead_nxt;
  logic                       tmin_r, tmin_nxt;
  logic [CW-1:0]              lpad_r, lpad_nxt;
  logic [CW-1:0]              rpad_r, rpad_nxt;
  logic [ifwp_pkg::ND_W-1:0]  nd_r, nd_nxt;
  logic [ifwp_pkg::DIG_W-1:0] dig_r, dig_nxt;
  logic                       zero_r, zero_nxt;
  logic                       upper_r, upper_nxt;
  logic                       ov_r, ov_nxt;
  logic [7:0]                 och_r, och_nxt;
  logic                       olast_r, olast_nxt;
  logic                       load, rem;
  logic [7:0]                 ch, padch;

  assign load  = busy_r && (!ov_r || out_ready);
  assign padch = zero_r ? ifwp_pkg::CH_ZERO : ifwp_pkg::CH_SPACE;

  always_comb begin
    busy_nxt  = busy_r;
    lead_nxt  = lead_r;
    tmin_nxt  = tmin_r;
    lpad_nxt  = lpad_r;
    rpad_nxt  = rpad_r;
    nd_nxt    = nd_r;
    dig_nxt   = dig_r;
    zero_nxt  = zero_r;
    upper_nxt = upper_r;
    ov_nxt    = ov_r;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    ch        = padch;
    if (lead_r) begin
      ch       = ifwp_pkg::CH_MINUS;
      lead_nxt = 1'b0;
    end else if (lpad_r != '0) begin
      lpad_nxt = lpad_r - 1'b1;
    end else if (tmin_r) begin
      ch       = ifwp_pkg::CH_MINUS;
      tmin_nxt = 1'b0;
    end else if (nd_r != '0) begin
      ch      = ifwp_pkg::digit_char(dig_r[ifwp_pkg::DIG_W-1 -: 4], upper_r);
      dig_nxt = {dig_r[ifwp_pkg::DIG_W-5:0], 4'h0};
      nd_nxt  = nd_r - 1'b1;
    end else begin
      rpad_nxt = rpad_r - 1'b1;
    end
    rem = lead_nxt || (lpad_nxt != '0) || tmin_nxt || (nd_nxt != '0) || (rpad_nxt != '0);
    if (load) begin
      ov_nxt    = 1'b1;
      och_nxt   = ch;
      olast_nxt = !rem;
      busy_nxt  = rem;
    end else begin
      lead_nxt = lead_r;
      tmin_nxt = tmin_r;
      lpad_nxt = lpad_r;
      rpad_nxt = rpad_r;
      nd_nxt   = nd_r;
      dig_nxt  = dig_r;
      if (out_ready) begin
        ov_nxt = 1'b0;
      end
    end
    if (start && !busy_r) begin
      busy_nxt  = 1'b1;
      lead_nxt  = job.lead_minus;
      tmin_nxt  = job.text_minus;
      lpad_nxt  = job.right_fill ? '0 : pad_cnt;
      rpad_nxt  = job.right_fill ? pad_cnt : '0;
      nd_nxt    = job.ndig;
      dig_nxt   = digits;
      zero_nxt  = job.zero_fill;
      upper_nxt = job.upper;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    lead_r  <= lead_nxt;
    tmin_r  <= tmin_nxt;
    lpad_r  <= lpad_nxt;
    rpad_r  <= rpad_nxt;
    nd_r    <= nd_nxt;
    dig_r   <= dig_nxt;
    zero_r  <= zero_nxt;
    upper_r <= upper_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
  end

  assign ready     = !busy_r;
  assign out_valid = ov_r;
  assign out_char  = och_r;
  assign out_last  = olast_r;

endmodule

>>> hw/rtl/integer_format_with_padding.sv
// integer to ascii formatter top level: request capture, sign and width handling
// A request carries a 32-bit value and format controls; the block returns the padded
// decimal or hex text one character per output request, the final one flagged with
// out_last. Decimal conversion is bit-serial (double dabble) over all 32 bits, then strips
// leading zero digits (up to 9); hex skips the bit steps and strips up to 7 digits. The
// digits then pass through the hand-over state and the sequencer's registers into the
// output register; after the first character the rest follow one per cycle while
// out_ready is high. A new request is taken as soon as the previous one has been
// handed to the sequencer, so its conversion overlaps the sending of the previous text.
module integer_format_with_padding #(
  parameter int MAX_WIDTH = ifwp_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_base_hex,
  input  logic        in_signed_mode,
  input  logic [5:0]  in_pad_width,
  input  logic [1:0]  in_pad_mode,
  input  logic        in_upper_case,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last
);

  localparam int CW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_HAND} state_t;

  state_t                       state_r;
  logic [CW-1:0]                width_r, pad_cnt_r, w_sat;
  logic                         zmin_r, tmin_r, pzero_r, pright_r, upper_r;
  logic                         accept, neg, zmin;
  logic [ifwp_pkg::VALUE_W-1:0] mag;
  logic                         conv_done;
  logic [ifwp_pkg::DIG_W-1:0]   conv_digits;
  logic [ifwp_pkg::ND_W-1:0]    conv_ndig, len;
  logic                         emit_ready, emit_start;
  ifwp_pkg::job_t               job;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign neg        = !in_base_hex && in_signed_mode && in_value[ifwp_pkg::VALUE_W-1];
  assign mag        = neg ? (ifwp_pkg::VALUE_W'(0) - in_value) : in_value;
  assign w_sat      = (32'(in_pad_width) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(in_pad_width);
  assign zmin       = neg && (in_pad_width != 6'd0) && in_pad_mode[ifwp_pkg::ZERO_FILL_BIT];
  assign len        = conv_ndig + ifwp_pkg::ND_W'(tmin_r);
  assign emit_start = (state_r == S_HAND) && emit_ready;

  always_comb begin
    job.lead_minus = zmin_r;
    job.text_minus = tmin_r;
    job.zero_fill  = pzero_r;
    job.right_fill = pright_r;
    job.upper      = upper_r;
    job.ndig       = conv_ndig;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state_r <= S_HAND;
          end
        end
        S_HAND: begin
          if (emit_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (accept) begin
      width_r  <= zmin ? w_sat - 1'b1 : w_sat;
      zmin_r   <= zmin;
      tmin_r   <= neg && !zmin;
      pzero_r  <= in_pad_mode[ifwp_pkg::ZERO_FILL_BIT];
      pright_r <= in_pad_mode[ifwp_pkg::RIGHT_FILL_BIT];
      upper_r  <= in_upper_case;
    end
    if (state_r == S_CONV && conv_done) begin
      pad_cnt_r <= (width_r > CW'(len)) ? width_r - CW'(len) : '0;
    end
  end

  ifwp_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .mag    (mag),
    .hex    (in_base_hex),
    .done   (conv_done),
    .digits (conv_digits),
    .ndig   (conv_ndig)
  );

  ifwp_emit #(
    .CW (CW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_start),
    .job       (job),
    .pad_cnt   (pad_cnt_r),
    .digits    (conv_digits),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

>>> hw/rtl/ifwp_checker.sv
// port-level checks for the integer formatter, bound to the top level
module ifwp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled result changed");

  // one request at a time in conversion
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while converting");

  // only digits, hex letters, sign and space appear
  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char >= 8'h30 && out_char <= 8'h39) ||
                   (out_char >= 8'h41 && out_char <= 8'h46) ||
                   (out_char >= 8'h61 && out_char <= 8'h66) ||
                   out_char == 8'h2D || out_char == 8'h20))
    else $error("unexpected character");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_format_with_padding ifwp_checker u_ifwp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .out_last  (out_last)
);

>>> verif/tb.sv
// self-checking testbench for the integer to ascii formatter with field padding
`timescale 1ns / 1ps

module tb;

  localparam int FIELD_MAX = ifwp_pkg::MAX_WIDTH_DEF;
  localparam int RAND_REQS = 410;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  class fmt_text_board;
    fmt_char_t   expected_text[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    // predicts the characters for one accepted request
    function void note_request(logic [31:0] value, logic hex, logic sgn, logic [5:0] pw,
                               logic [1:0] pm, logic up);
      logic [7:0]  line[$];
      logic [7:0]  body[$];
      logic [7:0]  padch;
      logic [31:0] mag;
      logic [31:0] radix;
      logic [31:0] d;
      logic        neg;
      int          cols;
      int          fill;
      fmt_char_t   c;
      cols = (pw > FIELD_MAX) ? FIELD_MAX : int'(pw);
      if (value == 32'd0) begin
        body.push_back(ifwp_pkg::CH_ZERO);
      end else begin
        neg = !hex && sgn && value[31];
        mag = neg ? (32'd0 - value) : value;
        radix = hex ? 32'd16 : 32'd10;
        while (mag != 32'd0) begin
          d = mag % radix;
          mag = mag / radix;
          if (d >= 32'd10) begin
            body.push_front((up ? 8'h41 : 8'h61) + d[7:0] - 8'd10);
          end else begin
            body.push_front(ifwp_pkg::CH_ZERO + d[7:0]);
          end
        end
        if (neg) begin
          if (cols != 0 && pm[ifwp_pkg::ZERO_FILL_BIT]) begin
            line.push_back(ifwp_pkg::CH_MINUS);
            cols--;
          end else begin
            body.push_front(ifwp_pkg::CH_MINUS);
          end
        end
      end
      padch = pm[ifwp_pkg::ZERO_FILL_BIT] ? ifwp_pkg::CH_ZERO : ifwp_pkg::CH_SPACE;
      fill = (body.size() >= cols) ? 0 : cols - body.size();
      if (!pm[ifwp_pkg::RIGHT_FILL_BIT]) repeat (fill) line.push_back(padch);
      foreach (body[i]) line.push_back(body[i]);
      if (pm[ifwp_pkg::RIGHT_FILL_BIT]) repeat (fill) line.push_back(padch);
      foreach (line[i]) begin
        c.ch = line[i];
        c.last = (i == line.size() - 1);
        expected_text.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      fmt_char_t e;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected char %h last %b", $time, ch, last);
        fails++;
        return;
      end
      e = expected_text.pop_front();
      if (ch !== e.ch) begin
        $display("%0t: char mismatch exp %h act %h", $time, e.ch, ch);
        fails++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch exp %b act %b", $time, e.last, last);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_value;
  logic        in_base_hex;
  logic        in_signed_mode;
  logic [5:0]  in_pad_width;
  logic [1:0]  in_pad_mode;
  logic        in_upper_case;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic        out_last;

  fmt_text_board board = new();

  integer_format_with_padding i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_base_hex   (in_base_hex),
    .in_signed_mode(in_signed_mode),
    .in_pad_width  (in_pad_width),
    .in_pad_mode   (in_pad_mode),
    .in_upper_case (in_upper_case),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last      (out_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_request(input logic [31:0] v, input logic hex, input logic sgn,
                              input logic [5:0] w, input logic [1:0] m, input logic up);
    in_valid       <= 1'b1;
    in_value       <= v;
    in_base_hex    <= hex;
    in_signed_mode <= sgn;
    in_pad_width   <= w;
    in_pad_mode    <= m;
    in_upper_case  <= up;
    do @(posedge clk); while (!in_ready);
    board.note_request(v, hex, sgn, w, m, up);
  endtask

  task automatic idle_gap(input bit allow);
    if (allow && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 20);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return p + $urandom_range(0, 2) - 32'd1;
      end
      3: return 32'd0 - $urandom_range(1, 1000);
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // receiver: random back-pressure, one long hold, one stretch always ready
  initial begin
    int  n_chars;
    bit  held;
    n_chars = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (!held && n_chars >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (n_chars >= 1200 && n_chars < 2000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 34);
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        board.check_char(out_char, out_last);
        n_chars++;
      end
    end
  end

  initial begin
    logic [31:0] v;
    logic        hex;
    logic        sgn;
    logic [5:0]  w;
    logic [1:0]  m;
    logic        up;
    int          pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_base_hex = 1'b0;
    in_signed_mode = 1'b0;
    in_pad_width = '0;
    in_pad_mode = '0;
    in_upper_case = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero, extremes, every pad mode, sign handling, saturation, no-pad cases
    send_request(32'h0000_0000, 1'b0, 1'b0, 6'd0,  2'd0, 1'b0);  idle_gap(1);
    send_request(32'h0000_0000, 1'b1, 1'b1, 6'd5,  2'd3, 1'b1);  idle_gap(1);
    send_request(32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0,  2'd0, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0,  2'd0, 1'b1);  idle_gap(1);
    send_request(32'hFFFF_FFFF, 1'b1, 1'b0, 6'd12, 2'd2, 1'b0);  idle_gap(1);
    send_request(32'h8000_0000, 1'b0, 1'b1, 6'd0,  2'd0, 1'b0);  idle_gap(1);
    send_request(32'h8000_0000, 1'b0, 1'b1, 6'd40, 2'd2, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFFB, 1'b0, 1'b1, 6'd6,  2'd2, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFFB, 1'b0, 1'b1, 6'd6,  2'd3, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFFB, 1'b0, 1'b1, 6'd6,  2'd0, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFFB, 1'b0, 1'b1, 6'd6,  2'd1, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFFF, 1'b0, 1'b1, 6'd1,  2'd2, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFF6, 1'b1, 1'b1, 6'd0,  2'd0, 1'b0);  idle_gap(1);
    send_request(32'h0000_0001, 1'b0, 1'b0, 6'd63, 2'd0, 1'b0);  idle_gap(1);
    send_request(32'h0000_0001, 1'b0, 1'b0, 6'd32, 2'd1, 1'b0);  idle_gap(1);
    send_request(32'h0000_0001, 1'b0, 1'b0, 6'd32, 2'd2, 1'b0);  idle_gap(1);
    send_request(32'h0000_0001, 1'b0, 1'b0, 6'd32, 2'd3, 1'b0);  idle_gap(1);
    send_request(32'd123456,    1'b0, 1'b0, 6'd1,  2'd3, 1'b0);  idle_gap(1);
    send_request(32'hDEAD_BEEF, 1'b1, 1'b0, 6'd8,  2'd0, 1'b0);  idle_gap(1);
    send_request(32'h00AB_CDEF, 1'b1, 1'b0, 6'd10, 2'd1, 1'b1);  idle_gap(1);
    send_request(32'h0000_0000, 1'b0, 1'b0, 6'd5,  2'd3, 1'b0);  idle_gap(1);
    send_request(32'h7FFF_FFFF, 1'b0, 1'b1, 6'd11, 2'd0, 1'b0);  idle_gap(1);
    send_request(32'hFFFF_FFFF, 1'b0, 1'b1, 6'd33, 2'd1, 1'b1);
    wait_drained();

    for (int k = 0; k < RAND_REQS; k++) begin
      v = rand_value();
      hex = 1'($urandom_range(0, 1));
      sgn = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = 6'($urandom_range(33, 63));
      end else if (pick < 4) begin
        w = 6'($urandom_range(0, 32));
      end else begin
        w = 6'($urandom_range(0, 12));
      end
      m = 2'($urandom_range(0, 3));
      up = 1'($urandom_range(0, 1));
      if (k == 300) begin
        wait_drained();
      end else begin
        idle_gap(!(k >= 120 && k < 200));
      end
      send_request(v, hex, sgn, w, m, up);
    end
    wait_drained();
    repeat (100) @(posedge clk);

    if (board.fails == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ifwp_pkg.sv
hw/rtl/ifwp_conv.sv
hw/rtl/ifwp_emit.sv
hw/rtl/integer_format_with_padding.sv
hw/rtl/ifwp_checker.sv
verif/tb.sv
